// File: design/dual_pedal_sensor_plausibility_core_assert.svh
// assertion macros for the pedal plausibility checker
`ifndef DUAL_PEDAL_SENSOR_PLAUSIBILITY_CORE_ASSERT_SVH
`define DUAL_PEDAL_SENSOR_PLAUSIBILITY_CORE_ASSERT_SVH
`define DPS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DPS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: design/dps_pkg.sv
// shared constants and types for the pedal plausibility block
package dps_pkg;
  localparam int FULL_SCALE = 1000;
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_READ_FAIL = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [2:0] REG_FIRST_MIN = 3'd0;
  localparam logic [2:0] REG_FIRST_MAX = 3'd1;
  localparam logic [2:0] REG_SECOND_MIN = 3'd2;
  localparam logic [2:0] REG_SECOND_MAX = 3'd3;
  localparam logic [2:0] REG_LOW_MARGIN = 3'd4;
  localparam logic [2:0] REG_HIGH_MARGIN = 3'd5;
  localparam logic [2:0] REG_MAX_DIFF = 3'd6;
  localparam logic [2:0] REG_CONFIRM = 3'd7;
  localparam int CFG_IDX_W = 8;

  typedef struct packed {
    logic [1:0] mode;
    logic [15:0] raw_first;
    logic [15:0] raw_second;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [5:0] status;
    logic [9:0] percent_first;
    logic [9:0] percent_second;
    logic [9:0] difference;
    logic [9:0] pedal;
    logic valid_res;
    logic [31:0] fault_elapsed;
  } out_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic cfg_ok;
    logic [31:0] now_ms;
    logic ok1;
    logic ok2;
    logic neg1;
    logic neg2;
    logic [31:0] num1;
    logic [31:0] num2;
    logic [16:0] den1;
    logic [16:0] den2;
  } job_t;

  typedef struct packed {
    logic clr;
  } ctl_t;
endpackage

// File: design/dps_if.sv
// valid/ready channel interfaces
interface dps_in_if (input logic clk);
  logic valid;
  logic ready;
  dps_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dps_out_if (input logic clk);
  logic valid;
  logic ready;
  dps_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dps_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [dps_pkg::CFG_IDX_W-1:0] index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: design/dual_pedal_sensor_plausibility_core.sv
// top level of the dual pedal sensor plausibility check
// channel  dir  transfer
// in_      in   mode, raw_first, raw_second, now_ms
// out_     out  status, percents, difference, pedal, valid_res, fault_elapsed
// cfg_     in   register index and write data, always ready
// an item passes from input transfer to result valid through the front (IDLE, MUL, OUT),
// the job queue and the back end (DIV1, DIV2, FIN): two 32-step divides on one shared divider
// front takes and prepares the next item while the back end divides
// reset is synchronous and clears control and fault state; no clearing pass
// a held result stalls the back end; the two-job queue then fills and the input stalls
module dual_pedal_sensor_plausibility_core (
  input logic clk,
  input logic rst_n,
  dps_in_if.sink in_ch,
  dps_out_if.source out_ch,
  dps_cfg_if.sink cfg_ch
);
  logic [15:0] fmin_r, fmax_r, smin_r, smax_r, lmar_r, hmar_r, conf_r;
  logic [9:0] maxd_r;
  logic q_full, q_push, q_empty, q_pop;
  dps_pkg::job_t qw, qr;
  dps_pkg::ctl_t ctl;
  logic wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;
  assign ctl.clr = wr && cfg_ch.index < {5'd0, dps_pkg::REG_LOW_MARGIN};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmin_r <= 16'd0; fmax_r <= 16'd4095; smin_r <= 16'd0; smax_r <= 16'd4095;
      lmar_r <= 16'd100; hmar_r <= 16'd100; maxd_r <= 10'd100; conf_r <= 16'd100;
    end else if (wr && cfg_ch.index[7:3] == 5'd0) begin
      case (cfg_ch.index[2:0])
        dps_pkg::REG_FIRST_MIN: fmin_r <= cfg_ch.wdata[15:0];
        dps_pkg::REG_FIRST_MAX: fmax_r <= cfg_ch.wdata[15:0];
        dps_pkg::REG_SECOND_MIN: smin_r <= cfg_ch.wdata[15:0];
        dps_pkg::REG_SECOND_MAX: smax_r <= cfg_ch.wdata[15:0];
        dps_pkg::REG_LOW_MARGIN: lmar_r <= cfg_ch.wdata[15:0];
        dps_pkg::REG_HIGH_MARGIN: hmar_r <= cfg_ch.wdata[15:0];
        dps_pkg::REG_MAX_DIFF: maxd_r <= cfg_ch.wdata[9:0];
        dps_pkg::REG_CONFIRM: conf_r <= cfg_ch.wdata[15:0];
        default: ;
      endcase
    end
  end

  dps_front u_front (
    .clk, .rst_n, .in_ch, .fmin(fmin_r), .fmax(fmax_r), .smin(smin_r), .smax(smax_r),
    .lmar(lmar_r), .hmar(hmar_r), .q_full, .q_push, .q_data(qw)
  );
  dps_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(qw), .full(q_full), .pop(q_pop),
    .empty(q_empty), .rdata(qr)
  );
  dps_back u_back (
    .clk, .rst_n, .q_empty, .job(qr), .q_pop, .maxd(maxd_r), .confirm(conf_r),
    .ctl, .out_ch
  );
endmodule

// File: design/dps_front.sv
// front end: range checks and divider operand setup
module dps_front (
  input  logic clk,
  input  logic rst_n,
  dps_in_if.sink in_ch,
  input  logic [15:0] fmin,
  input  logic [15:0] fmax,
  input  logic [15:0] smin,
  input  logic [15:0] smax,
  input  logic [15:0] lmar,
  input  logic [15:0] hmar,
  input  logic q_full,
  output logic q_push,
  output dps_pkg::job_t q_data
);
  logic [1:0] st_r, st_nxt;
  dps_pkg::in_item_t it_r;
  logic ok1_r, ok2_r;
  logic [32:0] p1_r, p2_r;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  function automatic logic rng_ok(input logic [15:0] r, input logic [15:0] a,
                                  input logic [15:0] b, input logic [15:0] lm,
                                  input logic [15:0] hm);
    logic [15:0] lo, hi;
    begin
      lo = (a < b) ? a : b;
      hi = (a > b) ? a : b;
      rng_ok = ({1'b0, r} + {1'b0, lm} >= {1'b0, lo}) &&
               ({1'b0, r} <= {1'b0, hi} + {1'b0, hm});
    end
  endfunction

  function automatic logic signed [32:0] mul_fs(input logic [15:0] r,
                                                input logic [15:0] a);
    logic signed [16:0] d;
    begin
      d = $signed({1'b0, r}) - $signed({1'b0, a});
      mul_fs = 33'(d) * 33'(dps_pkg::FULL_SCALE);
    end
  endfunction

  logic signed [16:0] sp1, sp2;
  assign sp1 = $signed({1'b0, fmax}) - $signed({1'b0, fmin});
  assign sp2 = $signed({1'b0, smax}) - $signed({1'b0, smin});

  assign in_ch.ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_ch.valid && in_ch.data.mode != dps_pkg::MODE_NONE) st_nxt = S_MUL;
      S_MUL: st_nxt = S_OUT;
      S_OUT: if (!q_full) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    if (st_r == S_IDLE && in_ch.valid) it_r <= in_ch.data;
    if (st_r == S_MUL) begin
      ok1_r <= rng_ok(it_r.raw_first, fmin, fmax, lmar, hmar);
      ok2_r <= rng_ok(it_r.raw_second, smin, smax, lmar, hmar);
      p1_r <= mul_fs(it_r.raw_first, fmin);
      p2_r <= mul_fs(it_r.raw_second, smin);
    end
  end

  always_comb begin
    q_push = (st_r == S_OUT) && !q_full;
    q_data.mode = it_r.mode;
    q_data.cfg_ok = (fmin != fmax) && (smin != smax);
    q_data.now_ms = it_r.now_ms;
    q_data.ok1 = ok1_r;
    q_data.ok2 = ok2_r;
    q_data.neg1 = p1_r[32] ^ sp1[16];
    q_data.neg2 = p2_r[32] ^ sp2[16];
    q_data.num1 = p1_r[32] ? 32'(-p1_r) : p1_r[31:0];
    q_data.num2 = p2_r[32] ? 32'(-p2_r) : p2_r[31:0];
    q_data.den1 = sp1[16] ? 17'(-sp1) : 17'(sp1);
    q_data.den2 = sp2[16] ? 17'(-sp2) : 17'(sp2);
  end
endmodule

// File: design/dps_queue.sv
// two-entry job queue between front and back
module dps_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  dps_pkg::job_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output dps_pkg::job_t rdata
);
  dps_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wdata;
  end
endmodule

// File: design/dps_back.sv
// back end: serial divides, difference check and fault timer
module dps_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  dps_pkg::job_t job,
  output logic q_pop,
  input  logic [9:0] maxd,
  input  logic [15:0] confirm,
  input  dps_pkg::ctl_t ctl,
  dps_out_if.source out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_FIN = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  logic [2:0] st_r;
  logic [5:0] cnt_r;
  logic [31:0] quo_r;
  logic [16:0] rem_r;
  logic [31:0] q1_r;
  logic tr_r, lf_r;
  logic [31:0] start_r, age_r;
  logic [3:0] pend_r, lat_r;
  logic ov_r;
  dps_pkg::out_item_t od_r;

  logic [31:0] num_s;
  logic [16:0] den_s;
  logic [17:0] trial;
  assign num_s = (st_r == S_DIV1) ? job.num1 : job.num2;
  assign den_s = (st_r == S_DIV1) ? job.den1 : job.den2;
  assign trial = {rem_r, num_s[5'(6'd31 - cnt_r)]} - {1'b0, den_s};

  function automatic logic [9:0] clampq(input logic [31:0] q, input logic neg);
    begin
      if (neg || q == 32'd0) clampq = 10'd0;
      else if (q > 32'(dps_pkg::FULL_SCALE)) clampq = 10'(dps_pkg::FULL_SCALE);
      else clampq = q[9:0];
    end
  endfunction

  logic [9:0] p1, p2, df;
  logic [4:0] inst;
  logic [3:0] timed;
  logic [31:0] age_new;
  logic tr_n, lf_n;
  logic [31:0] start_n;
  logic [3:0] pend_n, lat_n;
  logic [5:0] status;
  logic [10:0] sum;

  always_comb begin
    p1 = clampq(q1_r, job.neg1);
    p2 = clampq(quo_r, job.neg2);
    df = (p1 > p2) ? p1 - p2 : p2 - p1;
    inst = 5'd0;
    if (job.mode == dps_pkg::MODE_READ_FAIL) inst = {3'd0, 1'b1, ~job.cfg_ok};
    else if (!job.cfg_ok) inst = 5'd1;
    else inst = {df >= maxd, ~job.ok2, ~job.ok1, 2'b00};
    timed = inst[4:1];
    tr_n = tr_r; start_n = start_r; age_new = age_r; pend_n = pend_r;
    lat_n = lat_r; lf_n = lf_r;
    if (job.mode == dps_pkg::MODE_CLEAR) begin
      tr_n = 1'b0; start_n = '0; age_new = '0; pend_n = '0; lat_n = '0; lf_n = 1'b0;
    end else if (timed == 4'd0) begin
      tr_n = 1'b0; start_n = '0; age_new = '0; pend_n = '0;
    end else if (!tr_r || pend_r != timed) begin
      tr_n = 1'b1; start_n = job.now_ms; age_new = '0; pend_n = timed;
    end else begin
      age_new = job.now_ms - start_r;
      if (age_new >= {16'd0, confirm}) begin
        lf_n = 1'b1; lat_n = lat_r | timed;
      end
    end
    if (job.mode == dps_pkg::MODE_CLEAR) status = {5'd0, ~job.cfg_ok};
    else status = {lf_n, inst[4:1] | lat_n, inst[0]};
    sum = {1'b0, p1} + {1'b0, p2};
  end

  wire sample_ok = job.mode == dps_pkg::MODE_SAMPLE && job.cfg_ok;

  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;
  assign q_pop = (st_r == S_FIN) && !ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; tr_r <= 1'b0; lf_r <= 1'b0;
      start_r <= '0; age_r <= '0; pend_r <= '0; lat_r <= '0; cnt_r <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (!q_empty) begin
          st_r <= S_DIV1; cnt_r <= '0; rem_r <= '0;
        end
        S_DIV1, S_DIV2: begin
          quo_r <= {quo_r[30:0], !trial[17]};
          if (cnt_r == 6'd31) begin
            cnt_r <= '0;
            rem_r <= '0;
            if (st_r == S_DIV1) begin
              st_r <= S_DIV2;
              q1_r <= {quo_r[30:0], !trial[17]};
            end else st_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 6'd1;
            rem_r <= !trial[17] ? trial[16:0] : {rem_r[15:0], num_s[5'(6'd31 - cnt_r)]};
          end
        end
        S_FIN: if (!ov_r) begin
          st_r <= S_IDLE; ov_r <= 1'b1;
          od_r.status <= status;
          od_r.percent_first <= sample_ok ? p1 : 10'd0;
          od_r.percent_second <= sample_ok ? p2 : 10'd0;
          od_r.difference <= sample_ok ? df : 10'd0;
          od_r.pedal <= (sample_ok && inst == 5'd0 && !lf_n) ? sum[10:1] : 10'd0;
          od_r.valid_res <= sample_ok && inst == 5'd0 && !lf_n;
          od_r.fault_elapsed <= age_new;
        end
        default: st_r <= S_IDLE;
      endcase
      if (ctl.clr) begin
        tr_r <= 1'b0; lf_r <= 1'b0; start_r <= '0; age_r <= '0;
        pend_r <= '0; lat_r <= '0;
      end else if (st_r == S_FIN && !ov_r) begin
        tr_r <= tr_n; start_r <= start_n; age_r <= age_new; pend_r <= pend_n;
        lat_r <= lat_n; lf_r <= lf_n;
      end
    end
  end
endmodule

// File: design/dps_checker.sv
// port-level checker bound to the top level
`include "dual_pedal_sensor_plausibility_core_assert.svh"
module dps_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input dps_pkg::out_item_t out_data,
  input logic cfg_ready
);
  `DPS_ASSERT_IMP(a_pedal_zero, clk, rst_n, out_valid && !out_data.valid_res, out_data.pedal == 10'd0)
  `DPS_ASSERT_IMP(a_valid_clean, clk, rst_n, out_valid && out_data.valid_res, out_data.status == 6'd0)
  `DPS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `DPS_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
endmodule

bind dual_pedal_sensor_plausibility_core dps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data), .cfg_ready(cfg_ch.ready)
);
